// ===== rtl/nsrch_pkg.sv =====
// shared types, constants and functions for the header nonce search
package nsrch_pkg;

	localparam int unsigned Rounds = 64;

	typedef struct packed {
		logic [31:0] mr7;
		logic [31:0] tstamp;
		logic [31:0] bits;
		logic [31:0] nonce;
	} side_t;

	typedef struct packed {
		logic [7:0][31:0]  st;
		logic [15:0][31:0] w;
		logic [7:0][31:0]  cv;
		side_t             side;
	} cell_t;

	localparam logic [31:0] K [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// st[0] is a, st[7] is h
	localparam logic [7:0][31:0] IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

// ===== rtl/block_header_nonce_search.sv =====
// Double sha-256 nonce search over an 80-byte block header.
// Each transfer on the input channel (in_valid, in_stall, restart) is one
// attempt: restart high first reloads nonce and time from start_nonce and
// start_time. The header is built at the transfer from the merkle root and
// target bits registers and the current nonce and time, and the nonce then
// advances (the time steps when it wraps). The hash runs through three rows
// of 64 round cells (header block one, header block two, second hash) with a
// feed-forward register after the first two rows and the output register
// after the third; one attempt is accepted per cycle while in_stall is low.
// The output register holds found, tried_nonce, tried_time and digest_0..3;
// while it is full and out_stall is high the whole pipeline holds and
// in_stall is raised, so no attempt is lost or repeated.
// Configuration writes (cfg_we, cfg_idx, cfg_data) take effect at once; the user
// must make them while the block is idle, which the block does not enforce.
// Reset clears nonce, time, the configuration registers and every valid flag.
module block_header_nonce_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] tried_nonce,
	output logic [31:0] tried_time,
	output logic [63:0] digest_0,
	output logic [63:0] digest_1,
	output logic [63:0] digest_2,
	output logic [63:0] digest_3
);

	localparam logic [2:0] RegMr0   = 3'd0;
	localparam logic [2:0] RegMr1   = 3'd1;
	localparam logic [2:0] RegMr2   = 3'd2;
	localparam logic [2:0] RegMr3   = 3'd3;
	localparam logic [2:0] RegBits  = 3'd4;
	localparam logic [2:0] RegTime  = 3'd5;
	localparam logic [2:0] RegNonce = 3'd6;

	logic [63:0] mr0_q, mr1_q, mr2_q, mr3_q;
	logic [31:0] bits_q, stime_q, snonce_q;
	logic [31:0] nonce_q, time_q;
	logic [31:0] use_nonce, use_time, nxt_nonce;
	logic        adv, take;

	nsrch_pkg::cell_t a_in, a_out, b_in, b_out, c_in, c_out;
	logic             a_vld, b_vld, c_vld;
	nsrch_pkg::cell_t ff1_d, ff2_d;
	nsrch_pkg::cell_t ff1_s1, ff2_s2;
	logic             ff1_vld_s1, ff2_vld_s2;
	logic [7:0][31:0] h1, h2, h3;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign take     = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mr0_q    <= '0;
			mr1_q    <= '0;
			mr2_q    <= '0;
			mr3_q    <= '0;
			bits_q   <= '0;
			stime_q  <= '0;
			snonce_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegMr0:   mr0_q    <= cfg_data;
				RegMr1:   mr1_q    <= cfg_data;
				RegMr2:   mr2_q    <= cfg_data;
				RegMr3:   mr3_q    <= cfg_data;
				RegBits:  bits_q   <= cfg_data[31:0];
				RegTime:  stime_q  <= cfg_data[31:0];
				RegNonce: snonce_q <= cfg_data[31:0];
				default:  ;
			endcase
		end
	end

	assign use_nonce = restart ? snonce_q : nonce_q;
	assign use_time  = restart ? stime_q : time_q;
	assign nxt_nonce = use_nonce + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonce_q <= '0;
			time_q  <= '0;
		end else if (take) begin
			nonce_q <= nxt_nonce;
			// time steps when the nonce wraps
			time_q  <= (nxt_nonce == '0) ? use_time + 32'd3 : use_time;
		end
	end

	// first header block: version, zero previous hash, merkle bytes 0 to 27
	always_comb begin
		a_in = '0;
		a_in.st = nsrch_pkg::IV;
		a_in.cv = nsrch_pkg::IV;
		a_in.w[0]  = 32'h01000000;
		a_in.w[9]  = mr0_q[63:32];
		a_in.w[10] = mr0_q[31:0];
		a_in.w[11] = mr1_q[63:32];
		a_in.w[12] = mr1_q[31:0];
		a_in.w[13] = mr2_q[63:32];
		a_in.w[14] = mr2_q[31:0];
		a_in.w[15] = mr3_q[63:32];
		a_in.side.mr7    = mr3_q[31:0];
		a_in.side.tstamp = use_time;
		a_in.side.bits   = bits_q;
		a_in.side.nonce  = use_nonce;
	end

	nsrch_chain u_blk1 (
		.clk (clk), .arst_n (arst_n), .en (adv),
		.vld_in (take), .d_in (a_in), .vld_out (a_vld), .d_out (a_out)
	);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			h1[i] = a_out.cv[i] + a_out.st[i];
		end
	end

	// second header block with padding for 640 bits
	always_comb begin
		ff1_d       = '0;
		ff1_d.st    = h1;
		ff1_d.cv    = h1;
		ff1_d.side  = a_out.side;
		ff1_d.w[0]  = a_out.side.mr7;
		ff1_d.w[1]  = nsrch_pkg::bswap(a_out.side.tstamp);
		ff1_d.w[2]  = nsrch_pkg::bswap(a_out.side.bits);
		ff1_d.w[3]  = nsrch_pkg::bswap(a_out.side.nonce);
		ff1_d.w[4]  = 32'h80000000;
		ff1_d.w[15] = 32'h00000280;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff1_vld_s1 <= 1'b0;
		end else if (adv) begin
			ff1_vld_s1 <= a_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ff1_s1 <= ff1_d;
		end
	end

	assign b_in = ff1_s1;

	nsrch_chain u_blk2 (
		.clk (clk), .arst_n (arst_n), .en (adv),
		.vld_in (ff1_vld_s1), .d_in (b_in), .vld_out (b_vld), .d_out (b_out)
	);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			h2[i] = b_out.cv[i] + b_out.st[i];
		end
	end

	// second hash over the 32-byte first digest
	always_comb begin
		ff2_d        = '0;
		ff2_d.st     = nsrch_pkg::IV;
		ff2_d.cv     = nsrch_pkg::IV;
		ff2_d.side   = b_out.side;
		ff2_d.w[7:0] = h2;
		ff2_d.w[8]   = 32'h80000000;
		ff2_d.w[15]  = 32'h00000100;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff2_vld_s2 <= 1'b0;
		end else if (adv) begin
			ff2_vld_s2 <= b_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ff2_s2 <= ff2_d;
		end
	end

	assign c_in = ff2_s2;

	nsrch_chain u_hash2 (
		.clk (clk), .arst_n (arst_n), .en (adv),
		.vld_in (ff2_vld_s2), .d_in (c_in), .vld_out (c_vld), .d_out (c_out)
	);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			h3[i] = c_out.cv[i] + c_out.st[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= c_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found       <= (h3[5] == '0) && (h3[6] == '0) && (h3[7] == '0);
			tried_nonce <= c_out.side.nonce;
			tried_time  <= c_out.side.tstamp;
			digest_0    <= {h3[0], h3[1]};
			digest_1    <= {h3[2], h3[3]};
			digest_2    <= {h3[4], h3[5]};
			digest_3    <= {h3[6], h3[7]};
		end
	end

endmodule

// ===== rtl/nsrch_cell.sv =====
// one sha-256 round with its rolling message schedule window
module nsrch_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [31:0]          k,
	input  logic                 vld_in,
	input  nsrch_pkg::cell_t     d_in,
	output logic                 vld_out,
	output nsrch_pkg::cell_t     d_out
);

	logic [31:0] a, b, c, d, e, f, g, h;
	logic [31:0] t1, t2, sg0, sg1, wn;
	nsrch_pkg::cell_t nxt;

	always_comb begin
		a = d_in.st[0]; b = d_in.st[1]; c = d_in.st[2]; d = d_in.st[3];
		e = d_in.st[4]; f = d_in.st[5]; g = d_in.st[6]; h = d_in.st[7];
		t1 = h + (nsrch_pkg::rotr(e, 6) ^ nsrch_pkg::rotr(e, 11) ^ nsrch_pkg::rotr(e, 25))
			+ ((e & f) ^ (~e & g)) + k + d_in.w[0];
		t2 = (nsrch_pkg::rotr(a, 2) ^ nsrch_pkg::rotr(a, 13) ^ nsrch_pkg::rotr(a, 22))
			+ ((a & b) ^ (a & c) ^ (b & c));
		sg0 = nsrch_pkg::rotr(d_in.w[1], 7) ^ nsrch_pkg::rotr(d_in.w[1], 18)
			^ (d_in.w[1] >> 3);
		sg1 = nsrch_pkg::rotr(d_in.w[14], 17) ^ nsrch_pkg::rotr(d_in.w[14], 19)
			^ (d_in.w[14] >> 10);
		wn = d_in.w[0] + sg0 + d_in.w[9] + sg1;
		nxt = d_in;
		nxt.st[0] = t1 + t2;
		nxt.st[1] = a;
		nxt.st[2] = b;
		nxt.st[3] = c;
		nxt.st[4] = d + t1;
		nxt.st[5] = e;
		nxt.st[6] = f;
		nxt.st[7] = g;
		nxt.w[14:0] = d_in.w[15:1];
		nxt.w[15] = wn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

// ===== rtl/nsrch_chain.sv =====
// row of 64 round cells, one compression of a 64-byte block
module nsrch_chain (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  nsrch_pkg::cell_t d_in,
	output logic             vld_out,
	output nsrch_pkg::cell_t d_out
);

	logic             vld [nsrch_pkg::Rounds+1];
	nsrch_pkg::cell_t dat [nsrch_pkg::Rounds+1];

	assign vld[0] = vld_in;
	assign dat[0] = d_in;

	for (genvar i = 0; i < nsrch_pkg::Rounds; i++) begin : g_cell
		nsrch_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.k       (nsrch_pkg::K[i]),
			.vld_in  (vld[i]),
			.d_in    (dat[i]),
			.vld_out (vld[i+1]),
			.d_out   (dat[i+1])
		);
	end

	assign vld_out = vld[nsrch_pkg::Rounds];
	assign d_out   = dat[nsrch_pkg::Rounds];

endmodule

// ===== bench/testbench.sv =====
// testbench for the double sha-256 header nonce search
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned LatencyCycles = 194;
	localparam longint unsigned CycleLimit = 200000;

	typedef enum logic [2:0] {
		REG_MERKLE_0 = 3'd0,
		REG_MERKLE_1 = 3'd1,
		REG_MERKLE_2 = 3'd2,
		REG_MERKLE_3 = 3'd3,
		REG_TARGET_BITS = 3'd4,
		REG_START_TIME = 3'd5,
		REG_START_NONCE = 3'd6
	} reg_idx_e;

	typedef struct packed {
		logic        found;
		logic [31:0] nonce;
		logic [31:0] tstamp;
		logic [3:0][63:0] digest;
	} attempt_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        restart;
	logic        out_valid;
	logic        out_stall;
	logic        found;
	logic [31:0] tried_nonce;
	logic [31:0] tried_time;
	logic [63:0] digest_0;
	logic [63:0] digest_1;
	logic [63:0] digest_2;
	logic [63:0] digest_3;

	block_header_nonce_search dut (.*);

	// predictor copy of registers and search state
	logic [3:0][63:0] merkle;
	logic [31:0] bits_reg, start_time_reg, start_nonce_reg;
	logic [31:0] cur_nonce, cur_time;

	attempt_t expected_attempts[$];
	int errors = 0;
	longint unsigned cycles = 0;
	int in_idle_pct = 34;
	int out_idle_pct = 34;
	bit hold_off = 0;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] le32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// one compression; blk word 0 is the first big-endian word
	function automatic logic [7:0][31:0] compress(input logic [7:0][31:0] hv,
			input logic [15:0][31:0] blk);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
		e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ RoundK[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
		hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
		return hv;
	endfunction

	function automatic attempt_t hash_attempt(input logic do_restart);
		logic [7:0][31:0] iv, hv;
		logic [15:0][31:0] blk;
		attempt_t r;
		iv[0] = 32'h6a09e667; iv[1] = 32'hbb67ae85; iv[2] = 32'h3c6ef372;
		iv[3] = 32'ha54ff53a; iv[4] = 32'h510e527f; iv[5] = 32'h9b05688c;
		iv[6] = 32'h1f83d9ab; iv[7] = 32'h5be0cd19;
		if (do_restart) begin
			cur_nonce = start_nonce_reg;
			cur_time = start_time_reg;
		end
		// header words: version, zero prev hash (8), merkle words 9..16, ...
		blk = '0;
		blk[0] = le32(32'd1);
		for (int i = 0; i < 7; i++)
			blk[9 + i] = 32'(merkle[i / 2] >> (((i % 2) != 0) ? 0 : 32));
		hv = compress(iv, blk);
		blk = '0;
		blk[0] = merkle[3][31:0];
		blk[1] = le32(cur_time);
		blk[2] = le32(bits_reg);
		blk[3] = le32(cur_nonce);
		blk[4] = 32'h80000000;
		blk[15] = 32'd640;
		hv = compress(hv, blk);
		blk = '0;
		for (int i = 0; i < 8; i++) blk[i] = hv[i];
		blk[8] = 32'h80000000;
		blk[15] = 32'd256;
		hv = compress(iv, blk);
		for (int i = 0; i < 4; i++) r.digest[i] = {hv[2*i], hv[2*i+1]};
		r.found = (hv[5] == 32'd0) && (hv[6] == 32'd0) && (hv[7] == 32'd0);
		r.nonce = cur_nonce;
		r.tstamp = cur_time;
		cur_nonce = cur_nonce + 32'd1;
		if (cur_nonce == 32'd0) cur_time = cur_time + 32'd3;
		return r;
	endfunction

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stall, plus a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= hold_off || ($urandom_range(99) < out_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		attempt_t got, exp;
		if (arst_n && out_valid && !out_stall) begin
			got = {found, tried_nonce, tried_time, digest_0, digest_1, digest_2, digest_3};
			if (expected_attempts.size() == 0) begin
				errors++;
				$display("%0t: unexpected result nonce %h", $time, tried_nonce);
			end else begin
				exp = expected_attempts.pop_front();
				if (got.found !== exp.found) begin
					errors++;
					$display("%0t: found exp %b got %b", $time, exp.found, got.found);
				end
				if (got.nonce !== exp.nonce) begin
					errors++;
					$display("%0t: tried_nonce exp %h got %h", $time, exp.nonce, got.nonce);
				end
				if (got.tstamp !== exp.tstamp) begin
					errors++;
					$display("%0t: tried_time exp %h got %h", $time, exp.tstamp, got.tstamp);
				end
				for (int i = 0; i < 4; i++)
					if (got.digest[3-i] !== exp.digest[3-i]) begin
						errors++;
						$display("%0t: digest_%0d exp %h got %h", $time, i,
							exp.digest[3-i], got.digest[3-i]);
					end
			end
		end
	end

	// digest[i] packed index: digest_0 lands in the top word
	task automatic send_attempt(input logic rs);
		attempt_t e;
		cfg_we <= 1'b0;
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < in_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		e = hash_attempt(rs);
		// reorder to match packing of got (digest_0 most significant)
		e.digest = {e.digest[0], e.digest[1], e.digest[2], e.digest[3]};
		expected_attempts.push_back(e);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_attempts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_MERKLE_0: merkle[0] = val;
			REG_MERKLE_1: merkle[1] = val;
			REG_MERKLE_2: merkle[2] = val;
			REG_MERKLE_3: merkle[3] = val;
			REG_TARGET_BITS: bits_reg = val[31:0];
			REG_START_TIME: start_time_reg = val[31:0];
			REG_START_NONCE: start_nonce_reg = val[31:0];
			default: ;
		endcase
	endtask

	task automatic random_config();
		write_reg(REG_MERKLE_0, {$urandom, $urandom});
		write_reg(REG_MERKLE_1, {$urandom, $urandom});
		write_reg(REG_MERKLE_2, {$urandom, $urandom});
		write_reg(REG_MERKLE_3, {$urandom, $urandom});
		write_reg(REG_TARGET_BITS, {$urandom, $urandom});
		write_reg(REG_START_TIME, {$urandom, $urandom});
		write_reg(REG_START_NONCE, {$urandom, $urandom});
	endtask

	task automatic test_after_reset();
		// no restart: search starts from zero nonce and time
		repeat (3) send_attempt(1'b0);
		drain();
	endtask

	task automatic test_extremes();
		write_reg(REG_MERKLE_0, '1);
		write_reg(REG_MERKLE_1, '1);
		write_reg(REG_MERKLE_2, '1);
		write_reg(REG_MERKLE_3, '1);
		write_reg(REG_TARGET_BITS, '1);
		write_reg(REG_START_TIME, 64'hffff_fffe);
		write_reg(REG_START_NONCE, 64'hffff_fffe);
		// nonce wrap with time wrap
		send_attempt(1'b1);
		repeat (3) send_attempt(1'b0);
		send_attempt(1'b1);
		drain();
		write_reg(REG_TARGET_BITS, 64'h1d00ffff);
		write_reg(REG_START_TIME, 64'h0);
		write_reg(REG_START_NONCE, 64'h0);
		send_attempt(1'b1);
		// live register write without restart
		drain();
		write_reg(REG_MERKLE_2, 64'h0123_4567_89ab_cdef);
		repeat (2) send_attempt(1'b0);
		drain();
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			repeat (400) send_attempt($urandom_range(19) == 0);
			begin
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		drain();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			random_config();
			in_idle_pct = (phase == 2) ? 0 : 34;
			out_idle_pct = (phase == 2) ? 0 : 34;
			send_attempt(1'b1);
			repeat (224) send_attempt($urandom_range(15) == 0);
			drain();
		end
		in_idle_pct = 34;
		out_idle_pct = 34;
	endtask

	initial begin
		merkle = '0;
		bits_reg = '0;
		start_time_reg = '0;
		start_nonce_reg = '0;
		cur_nonce = '0;
		cur_time = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MERKLE_0;
		cfg_data = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_extremes();
		test_backpressure();
		test_random();
		drain();
		repeat (LatencyCycles + 20) @(posedge clk);
		if (errors == 0 && expected_attempts.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
